### design/itcf_pkg.sv
package itcf_pkg;

  // Configuration register indexes
  localparam logic REG_GYRO_WEIGHT      = 1'b0;
  localparam logic REG_GYRO_SENSITIVITY = 1'b1;

  localparam int CFG_DATA_W   = 17;
  localparam int ATAN_TAB_LEN = 24;
  localparam int Z_FRAC       = 24;
  localparam int GUARD_SHIFT  = 10;

  localparam logic [16:0] WEIGHT_ONE    = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET  = 17'd64881;
  localparam logic [15:0] SENS_RESET    = 16'd131;
  localparam logic [19:0] US_PER_SECOND = 20'd1000000;

  // Settings shared by both lanes, already clamped to their legal ranges.
  typedef struct packed {
    logic [16:0] weight;
    logic [15:0] sens;
  } lane_cfg_t;

  // atan(2^-i) in degrees, 24 fraction bits.
  function automatic logic [29:0] atan_tab(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### design/itcf_cordic.sv
module itcf_cordic #(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  output logic               busy,
  output logic signed [31:0] angle
);

  localparam int N      = (ITERATIONS < itcf_pkg::ATAN_TAB_LEN) ? ITERATIONS
                                                                : itcf_pkg::ATAN_TAB_LEN;
  localparam int XW     = 29;
  localparam int ZW     = 35;
  localparam int RSHIFT = itcf_pkg::Z_FRAC - FRAC_BITS;

  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [4:0]           idx;

  logic signed [XW-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0] off, tab, z_round;

  always_comb begin
    x0  = XW'(x_in);
    y0  = XW'(y_in);
    off = '0;
    if (x_in < 0) begin
      off = (y_in >= 0) ? (ZW'(180) <<< itcf_pkg::Z_FRAC)
                        : -(ZW'(180) <<< itcf_pkg::Z_FRAC);
      x0  = -x0;
      y0  = -y0;
    end
    xs  = x >>> idx;
    ys  = y >>> idx;
    tab = ZW'(signed'({1'b0, itcf_pkg::atan_tab(idx)}));
    z_round = z + (ZW'(1) <<< (RSHIFT - 1));
  end

  assign angle = 32'(z_round >>> RSHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      z    <= '0;
    end else if (start) begin
      idx <= '0;
      x   <= x0 <<< itcf_pkg::GUARD_SHIFT;
      y   <= y0 <<< itcf_pkg::GUARD_SHIFT;
      // Both operands zero gives zero; a zero y needs only the quadrant offset.
      if (x_in == 0 && y_in == 0) begin
        z    <= '0;
        busy <= 1'b0;
      end else begin
        z    <= off;
        busy <= (y0 != 0);
      end
    end else if (busy) begin
      if (y < 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tab;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tab;
      end
      idx <= idx + 5'd1;
      if (idx == 5'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### design/itcf_div.sv
module itcf_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den, rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem, num[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den});
  assign quot   = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= num_in;
      den  <= den_in;
      rem  <= '0;
    end else if (busy) begin
      rem <= fits ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
      num <= {num[NUM_W-2:0], fits};
      cnt <= cnt + CW'(1);
      if (cnt == CW'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### design/itcf_lane.sv
module itcf_lane #(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                commit,
  input  itcf_pkg::lane_cfg_t cfg,
  input  logic signed [16:0]  atan_y,
  input  logic signed [16:0]  atan_x,
  input  logic signed [15:0]  gyro,
  input  logic [15:0]         elapsed_us,
  output logic                done,
  output logic signed [31:0]  result
);

  localparam int DEN_W = 36;
  localparam int MAG_W = 33;
  localparam int NUM_W = ((MAG_W - 2 + FRAC_BITS > DEN_W) ? (MAG_W - 2 + FRAC_BITS)
                                                          : DEN_W) + 1;
  localparam int DW    = FRAC_BITS + 13;
  localparam int SW    = ((DW > 32) ? DW : 32) + 1;
  localparam int HW    = SW - 17;
  localparam int TW    = SW + 20;
  localparam int VW    = TW - 16;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_PREP = 7'b0000010,
    PH_DIV  = 7'b0000100,
    PH_ADD  = 7'b0001000,
    PH_MUL  = 7'b0010000,
    PH_SUM  = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  phase_t phase;

  logic signed [31:0]    angle_reg;
  logic                  g_neg;
  logic [MAG_W-1:0]      mag;
  logic [DEN_W-1:0]      den;
  logic signed [SW-1:0]  s;
  logic [33:0]           p_lo;
  logic signed [HW+17:0] p_hi;
  logic signed [49:0]    p_acc;

  logic                  cordic_busy, div_busy, div_start;
  logic signed [31:0]    accel;
  logic [NUM_W-1:0]      quot, num;
  logic [16:0]           g_abs;
  logic signed [DW-1:0]  delta;
  logic [16:0]           w_acc;
  logic signed [TW-1:0]  total;
  logic signed [VW-1:0]  v;

  itcf_cordic #(
    .ITERATIONS (ITERATIONS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .y_in  (atan_y),
    .x_in  (atan_x),
    .busy  (cordic_busy),
    .angle (accel)
  );

  itcf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (num),
    .den_in (den),
    .busy   (div_busy),
    .quot   (quot)
  );

  always_comb begin
    g_abs     = gyro[15] ? 17'(-{gyro[15], gyro}) : {1'b0, gyro};
    num       = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(den >> 1);
    div_start = (phase == PH_PREP);
    delta     = g_neg ? -DW'(signed'({1'b0, quot[DW-2:0]}))
                      : DW'(signed'({1'b0, quot[DW-2:0]}));
    w_acc     = itcf_pkg::WEIGHT_ONE - cfg.weight;
    total     = (TW'(p_hi) <<< 17) + TW'(signed'({1'b0, p_lo}))
              + TW'(p_acc) + TW'(32768);
    v         = VW'(total >>> 16);
  end

  assign done = (phase == PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      angle_reg <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            g_neg <= gyro[15];
            mag   <= MAG_W'(g_abs * elapsed_us);
            den   <= DEN_W'(cfg.sens * itcf_pkg::US_PER_SECOND);
            phase <= PH_PREP;
          end
        end
        PH_PREP: phase <= PH_DIV;
        PH_DIV: begin
          if (!div_busy && !cordic_busy) begin
            phase <= PH_ADD;
          end
        end
        PH_ADD: begin
          s     <= SW'(angle_reg) + SW'(delta);
          phase <= PH_MUL;
        end
        PH_MUL: begin
          p_lo  <= cfg.weight * s[16:0];
          p_hi  <= signed'({1'b0, cfg.weight}) * (s >>> 17);
          p_acc <= signed'({1'b0, w_acc}) * accel;
          phase <= PH_SUM;
        end
        PH_SUM: begin
          if (v > VW'(32'sh7fffffff)) begin
            result <= 32'sh7fffffff;
          end else if (v < -VW'(33'sh080000000)) begin
            result <= 32'sh80000000;
          end else begin
            result <= 32'(v);
          end
          phase <= PH_DONE;
        end
        PH_DONE: begin
          if (commit) begin
            angle_reg <= result;
            phase     <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

### design/imu_tilt_complementary_filter_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  accel_x/y/z, gyro_x/y, elapsed_us
// output    out        out_valid/out_stall  roll_out, pitch_out
// config    in         cfg_write            cfg_index, cfg_data
//
// A transaction runs from acceptance until the result is in the output register; its length is
// set by the bit-serial gyro divider in each lane, and the CORDIC runs beside it.
// Reset clears the stored roll and pitch angles and loads the register defaults.
// in_stall is high while a transaction is in the lanes; a waiting output does not block
// acceptance, only the hand-off of the next result.
module imu_tilt_complementary_filter_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  gyro_x,
  input  logic signed [15:0]  gyro_y,
  input  logic [15:0]         elapsed_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  roll_out,
  output logic signed [31:0]  pitch_out,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [itcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [16:0] gyro_weight;
  logic [15:0] gyro_sensitivity;
  logic        busy;

  itcf_pkg::lane_cfg_t lane_cfg;
  logic               accept, load;
  logic               roll_done, pitch_done;
  logic signed [31:0] roll_res, pitch_res;
  logic signed [16:0] az_ext, ay_ext, ax_neg;

  // Out-of-range register values are clamped before they reach the lanes.
  always_comb begin
    lane_cfg.weight = (gyro_weight > itcf_pkg::WEIGHT_ONE) ? itcf_pkg::WEIGHT_ONE
                                                           : gyro_weight;
    lane_cfg.sens   = (gyro_sensitivity == 16'd0) ? 16'd1 : gyro_sensitivity;
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  // The merge stage takes both lane results together once the output register is free.
  assign load     = busy && roll_done && pitch_done && (!out_valid || !out_stall);

  assign az_ext = 17'(accel_z);
  assign ay_ext = 17'(accel_y);
  assign ax_neg = -17'(accel_x);

  // Roll lane: atan2(accel_y, accel_z) blended with integrated gyro_x.
  itcf_lane #(
    .ITERATIONS (CORDIC_ITERATIONS),
    .FRAC_BITS  (ANGLE_FRAC_BITS)
  ) u_roll (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .commit     (load),
    .cfg        (lane_cfg),
    .atan_y     (ay_ext),
    .atan_x     (az_ext),
    .gyro       (gyro_x),
    .elapsed_us (elapsed_us),
    .done       (roll_done),
    .result     (roll_res)
  );

  // Pitch lane: atan2(-accel_x, accel_z) blended with integrated gyro_y.
  itcf_lane #(
    .ITERATIONS (CORDIC_ITERATIONS),
    .FRAC_BITS  (ANGLE_FRAC_BITS)
  ) u_pitch (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .commit     (load),
    .cfg        (lane_cfg),
    .atan_y     (ax_neg),
    .atan_x     (az_ext),
    .gyro       (gyro_y),
    .elapsed_us (elapsed_us),
    .done       (pitch_done),
    .result     (pitch_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight      <= itcf_pkg::WEIGHT_RESET;
      gyro_sensitivity <= itcf_pkg::SENS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        itcf_pkg::REG_GYRO_WEIGHT:      gyro_weight      <= cfg_data;
        itcf_pkg::REG_GYRO_SENSITIVITY: gyro_sensitivity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      roll_out  <= roll_res;
      pitch_out <= pitch_res;
    end
  end

endmodule
